// ===== rtl/core/rdm_pkg.sv =====
// package for the dot-star regex matcher: sizes, register indexes, cell control
// no dependencies
package rdm_pkg;

    localparam int TOKENS     = 16;
    localparam int POSITIONS  = TOKENS + 1;
    localparam int CNT_W      = $clog2(POSITIONS);
    localparam int CHAR_W     = 8;
    localparam int CHARS_W    = 64;
    localparam int STAR_W     = 16;
    localparam int TCOUNT_W   = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CHAR_W-1:0] DOT_BYTE = 8'd46;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHARS_LOW  = 2'd0,
        REG_CHARS_HIGH = 2'd1,
        REG_STAR_MASK  = 2'd2,
        REG_TOKEN_CNT  = 2'd3
    } reg_index_t;

    // per-transfer control broadcast along the cell row
    typedef struct packed {
        logic              load;
        logic              restart;
        logic [CHAR_W-1:0] text_char;
    } step_ctl_t;

endpackage

// ===== rtl/core/rdm_in_if.sv =====
// input channel of the matcher: kind and text byte with valid/ready
// depends on rdm_pkg
interface rdm_in_if
    import rdm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [CHAR_W-1:0] text_char;

    modport source (output valid, output kind, output text_char, input ready);
    modport sink   (input valid, input kind, input text_char, output ready);
endinterface

// ===== rtl/core/rdm_out_if.sv =====
// result channel of the matcher: matched and alive flags with valid/ready
// no dependencies
interface rdm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic alive;

    modport source (output valid, output matched, output alive, input ready);
    modport sink   (input valid, input matched, input alive, output ready);
endinterface

// ===== rtl/core/rdm_cell.sv =====
// one token cell: holds the reached bit of the position after its token
// depends on rdm_pkg
module rdm_cell
    import rdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  step_ctl_t         ctl,
    input  logic [CHAR_W-1:0] tok_char,
    input  logic              starred,
    input  logic              in_use,
    input  logic              closed_in,
    input  logic              back_in,
    output logic              closed_out,
    output logic              back_out
);

    logic act_reg;
    logic act_next;
    logic hit;
    logic fwd;

    // closure: own bit kept, plus empty move over a starred token
    assign closed_out = in_use & (act_reg | (closed_in & starred));

    assign hit      = closed_in & in_use & ((tok_char == DOT_BYTE) || (tok_char == ctl.text_char));
    assign fwd      = hit & ~starred;
    assign back_out = hit & starred;

    assign act_next = ctl.restart ? 1'b0 : (fwd | back_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            act_reg <= act_next;
        end
    end

endmodule

// ===== rtl/core/regex_dot_star_matcher.sv =====
// a transfer updates the positions; its result is registered once the output register is free
// throughput: one item per cycle unless stalled, cell row closure ripple sets the clock period
// the output register lets a new input transfer while a result waits
// reset: only position zero reached, all pattern registers zero, no result pending
// depends on rdm_pkg, rdm_in_if, rdm_out_if, rdm_cell
module regex_dot_star_matcher
    import rdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    rdm_in_if.sink                text,
    rdm_out_if.source             verdict
);

    // pattern registers
    logic [CHARS_W-1:0]   chars_low_reg;
    logic [CHARS_W-1:0]   chars_high_reg;
    logic [STAR_W-1:0]    star_mask_reg;
    logic [TCOUNT_W-1:0]  token_count_reg;

    // position zero lives here, positions 1..TOKENS live in the cells
    logic                 pos0_reg;
    logic                 pos0_next;

    // a transfer has updated the positions, its result is not yet registered
    logic                 pend_reg;
    logic                 pend_next;

    // result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 matched_reg;
    logic                 matched_next;
    logic                 alive_reg;
    logic                 alive_next;

    logic [CNT_W-1:0]     cnt;
    logic [TOKENS-1:0]    in_use;
    logic [2*CHARS_W-1:0] chars_all;
    logic [POSITIONS-1:0] closed_pos;
    logic [TOKENS:0]      back;
    logic                 in_fire;
    logic                 load_fire;
    step_ctl_t            ctl;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_low_reg   <= '0;
            chars_high_reg  <= '0;
            star_mask_reg   <= '0;
            token_count_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_CHARS_LOW:  chars_low_reg   <= wr_data;
                REG_CHARS_HIGH: chars_high_reg  <= wr_data;
                REG_STAR_MASK:  star_mask_reg   <= wr_data[STAR_W-1:0];
                REG_TOKEN_CNT:  token_count_reg <= wr_data[TCOUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // token count clipped to the cell row
    assign cnt = (token_count_reg > TCOUNT_W'(TOKENS)) ? CNT_W'(TOKENS)
                                                       : token_count_reg[CNT_W-1:0];
    assign chars_all = {chars_high_reg, chars_low_reg};

    // handshake: take a new item unless an update still waits for the result register
    assign load_fire = pend_reg & (~out_valid_reg | verdict.ready);
    assign text.ready = ~pend_reg | load_fire;
    assign in_fire    = text.valid & text.ready;

    assign ctl.load      = in_fire;
    assign ctl.restart   = text.kind;
    assign ctl.text_char = text.text_char;

    // position zero is always within the kept range
    assign closed_pos[0] = pos0_reg;
    assign back[TOKENS]  = 1'b0;

    // cell row: closure ripples left to right, starred self-loops hand back to the left
    for (genvar j = 0; j < TOKENS; j++)
    begin : g_cell
        assign in_use[j] = (CNT_W'(j) < cnt);

        rdm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .tok_char   (chars_all[j*CHAR_W +: CHAR_W]),
            .starred    (star_mask_reg[j]),
            .in_use     (in_use[j]),
            .closed_in  (closed_pos[j]),
            .back_in    (back[j+1]),
            .closed_out (closed_pos[j+1]),
            .back_out   (back[j])
        );
    end

    // restart reaches position zero only, a text byte keeps it only via a starred token 0
    assign pos0_next = text.kind ? 1'b1 : back[0];

    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        matched_next   = matched_reg;
        alive_next     = alive_reg;
        if (out_valid_reg && verdict.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_fire)
        begin
            // positions are final here, so the closed set gives the result
            out_valid_next = 1'b1;
            matched_next   = closed_pos[cnt];
            alive_next     = |closed_pos;
            pend_next      = 1'b0;
        end
        if (in_fire)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos0_reg      <= 1'b1;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                pos0_reg <= pos0_next;
            end
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        alive_reg   <= alive_next;
    end

    assign verdict.valid   = out_valid_reg;
    assign verdict.matched = matched_reg;
    assign verdict.alive   = alive_reg;

endmodule

// ===== rtl/core/rdm_checker.sv =====
// port-level checks for the dot-star matcher, bound to the top level
// depends on regex_dot_star_matcher
module rdm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic matched,
    input logic alive
);

    logic [1:0] outstanding_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid & in_ready;
    assign out_xfer = out_valid & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 2'(in_xfer) - 2'(out_xfer);
        end
    end

    // a result waiting on a stall keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(alive))
        else $error("result changed while stalled");

    // a whole-pattern match implies a live position
    a_match_alive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> alive)
        else $error("matched without a live position");

    // no result without an item in flight
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outstanding_reg != 2'd0)
        else $error("result with no item outstanding");

    // at most one item in update plus one in the result register
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 2'd2 |-> !in_ready || out_xfer)
        else $error("input taken beyond the two item depth");

endmodule

bind regex_dot_star_matcher rdm_checker u_rdm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text.valid),
    .in_ready  (text.ready),
    .out_valid (verdict.valid),
    .out_ready (verdict.ready),
    .matched   (verdict.matched),
    .alive     (verdict.alive)
);
